// ----- design/glmd_pkg.sv -----
// shared types, constants and helpers of the grid local minimum detector
`default_nettype none

package glmd_pkg;

    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 1024;
    localparam int VALUE_BITS = 16;

    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int HEIGHT_BITS = 9;
    localparam int WIDTH_BITS  = 11;
    localparam int PHASE_BITS  = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 11;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAP_WIDTH    = 3'd0,
        CFG_MAP_HEIGHT   = 3'd1,
        CFG_ALIGN_ENABLE = 3'd2,
        CFG_ALIGN_PERIOD = 3'd3,
        CFG_ALIGN_OFFSET = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic                  present;
        logic [VALUE_BITS-1:0] value;
    } t_cell;

    // 3x3 window around the reported cell: cm/c0/cp column -1/0/+1, rm/r0/rp row -1/0/+1
    typedef struct packed {
        t_cell self;
        t_cell cm_rm;
        t_cell cm_r0;
        t_cell cm_rp;
        t_cell c0_rm;
        t_cell c0_rp;
        t_cell cp_rm;
        t_cell cp_r0;
        t_cell cp_rp;
    } t_window;

    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
        logic aligned;
    } t_edge_flags;

    function automatic logic smaller(input t_cell nb, input t_cell ref_cell);
        smaller = nb.present && (nb.value < ref_cell.value);
    endfunction

endpackage

`default_nettype wire

// ----- design/glmd_line_ram.sv -----
// one-column line store: 17-bit cells, registered read, old data on a same-address write
`default_nettype none

module glmd_line_ram (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire  [glmd_pkg::ROW_BITS-1:0] i_wr_addr,
    input  glmd_pkg::t_cell              i_wr_data,
    input  wire                          i_rd_en,
    input  wire  [glmd_pkg::ROW_BITS-1:0] i_rd_addr,
    output glmd_pkg::t_cell              o_rd_data
);
    import glmd_pkg::*;

    t_cell r_mem [MAX_HEIGHT];
    t_cell r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- design/glmd_window_eval.sv -----
// non-strict local minimum over the 3x3 window, honouring map edges and diagonal mode
`default_nettype none

module glmd_window_eval (
    input  glmd_pkg::t_window     i_win,
    input  glmd_pkg::t_edge_flags i_flags,
    output logic                  o_is_min
);
    import glmd_pkg::*;

    logic cm, cp, rm, rp, full;
    logic hit;

    always_comb begin
        cm   = !i_flags.col_first;
        cp   = !i_flags.col_last;
        rm   = !i_flags.row_first;
        rp   = !i_flags.row_last;
        full = !i_flags.aligned;
        hit  = (cm && rm && smaller(i_win.cm_rm, i_win.self))
            || (full && cm && smaller(i_win.cm_r0, i_win.self))
            || (full && cm && rp && smaller(i_win.cm_rp, i_win.self))
            || (full && rm && smaller(i_win.c0_rm, i_win.self))
            || (full && rp && smaller(i_win.c0_rp, i_win.self))
            || (full && cp && rm && smaller(i_win.cp_rm, i_win.self))
            || (full && cp && smaller(i_win.cp_r0, i_win.self))
            || (cp && rp && smaller(i_win.cp_rp, i_win.self));
        o_is_min = i_win.self.present && !hit;
    end

endmodule

`default_nettype wire

// ----- design/grid_local_minimum_detector_core.sv -----
// top level of the grid local minimum detector
// Takes one map cell per clock in column-major order and returns one result per cell, one
// cell per clock sustained unless stalled. Each result leaves map_height+1 items after
// its cell arrived: the first map_height+1 items of a map only fill the window, and
// map_height+1 pad items after the last cell flush the tail. Past the fill, each item
// gives its result through the window and output registers. Two 256-entry line stores
// give the one- and two-column delays, one read and one write per item each, so the
// window slides by one cell per item. The alignment residue follows a phase counter.
// Configuration is taken whenever offered and must only change between maps.
`default_nettype none

module grid_local_minimum_detector_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [glmd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [glmd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_mode,
    input  wire  [glmd_pkg::VALUE_BITS-1:0]    i_cell_value,
    input  wire                                i_cell_present,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_is_local_min,
    output logic [glmd_pkg::COL_BITS-1:0]      o_cell_column,
    output logic [glmd_pkg::ROW_BITS-1:0]      o_cell_row,
    output logic                               o_last_cell
);
    import glmd_pkg::*;

    // configuration
    logic [WIDTH_BITS-1:0]  r_map_width;
    logic [HEIGHT_BITS-1:0] r_map_height;
    logic                   r_align_enable;
    logic [PHASE_BITS-1:0]  r_align_period;
    logic [PHASE_BITS-1:0]  r_align_offset;

    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;

    // front counters
    logic [HEIGHT_BITS-1:0] r_fill,  n_fill;
    logic [ROW_BITS-1:0]    r_wp,    n_wp;
    logic [ROW_BITS-1:0]    r_wp_prev;
    logic [COL_BITS-1:0]    r_rc,    n_rc;
    logic [ROW_BITS-1:0]    r_rr,    n_rr;
    logic [PHASE_BITS-1:0]  r_cph,   n_cph;
    logic [PHASE_BITS-1:0]  r_ph,    n_ph;

    // window stage
    logic        r_s_res;
    logic [COL_BITS-1:0] r_s_col;
    logic [ROW_BITS-1:0] r_s_row;
    logic        r_s_last;
    t_edge_flags r_s_flags, n_flags;
    t_cell       r_cur, r_t1, r_t2;
    t_cell       m1, r_m1a, r_m1b;
    t_cell       m2, r_m2a, r_m2b;

    // output stage
    logic                r_ov;
    logic                r_o_min;
    logic [COL_BITS-1:0] r_o_col;
    logic [ROW_BITS-1:0] r_o_row;
    logic                r_o_last;

    logic     in_acc, s_adv, filling, res_last;
    t_cell    item;
    t_window  win;
    logic     is_min;
    logic [PHASE_BITS-1:0] residue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= WIDTH_BITS'(1);
            r_map_height   <= HEIGHT_BITS'(MAX_HEIGHT);
            r_align_enable <= 1'b0;
            r_align_period <= '0;
            r_align_offset <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:    r_map_width    <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_data[HEIGHT_BITS-1:0];
                CFG_ALIGN_ENABLE: r_align_enable <= i_cfg_data[0];
                CFG_ALIGN_PERIOD: r_align_period <= i_cfg_data[PHASE_BITS-1:0];
                CFG_ALIGN_OFFSET: r_align_offset <= i_cfg_data[PHASE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_map_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (r_map_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_map_width;
        end
        if (r_map_height == '0) begin
            h_eff = HEIGHT_BITS'(1);
        end else if (r_map_height > HEIGHT_BITS'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_map_height;
        end
    end

    assign s_adv      = !r_ov || i_out_ready;
    assign o_in_ready = !r_s_res || s_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        item.present = !i_mode && i_cell_present;
        item.value   = item.present ? i_cell_value : '0;
    end

    // front: position of the cell whose result this request completes
    always_comb begin
        filling = {1'b0, r_fill} < ({1'b0, h_eff} + (HEIGHT_BITS + 1)'(1));
        residue = (r_align_period == '0) ? '0 : r_ph;
        n_flags.col_first = (r_rc == '0);
        n_flags.col_last  = ({1'b0, r_rc} + WIDTH_BITS'(1)) >= w_eff;
        n_flags.row_first = (r_rr == '0);
        n_flags.row_last  = ({1'b0, r_rr} + HEIGHT_BITS'(1)) >= h_eff;
        n_flags.aligned   = r_align_enable && (residue == r_align_offset);
        res_last = n_flags.col_last && n_flags.row_last;

        n_fill = r_fill;
        n_rc   = r_rc;
        n_rr   = r_rr;
        n_cph  = r_cph;
        n_ph   = r_ph;
        if (({1'b0, r_wp} + HEIGHT_BITS'(1)) >= h_eff) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + ROW_BITS'(1);
        end

        if (filling) begin
            n_fill = r_fill + HEIGHT_BITS'(1);
        end else if (res_last) begin
            // end of map: everything restarts for the next one
            n_fill = '0;
            n_wp   = '0;
            n_rc   = '0;
            n_rr   = '0;
            n_cph  = '0;
            n_ph   = '0;
        end else if (n_flags.row_last) begin
            n_rr = '0;
            n_rc = r_rc + COL_BITS'(1);
            if (r_align_period == '0
                || ({1'b0, r_cph} + (PHASE_BITS + 1)'(1)) >= {1'b0, r_align_period}) begin
                n_cph = '0;
            end else begin
                n_cph = r_cph + PHASE_BITS'(1);
            end
            n_ph = n_cph;
        end else begin
            n_rr = r_rr + ROW_BITS'(1);
            if (r_align_period == '0) begin
                n_ph = '0;
            end else if (r_ph == '0 || r_ph >= r_align_period) begin
                n_ph = r_align_period - PHASE_BITS'(1);
            end else begin
                n_ph = r_ph - PHASE_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_wp      <= '0;
            r_wp_prev <= '0;
            r_rc      <= '0;
            r_rr      <= '0;
            r_cph     <= '0;
            r_ph      <= '0;
            r_s_res   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill    <= n_fill;
                r_wp      <= n_wp;
                r_wp_prev <= r_wp;
                r_rc      <= n_rc;
                r_rr      <= n_rr;
                r_cph     <= n_cph;
                r_ph      <= n_ph;
                r_s_res   <= !filling;
            end else if (s_adv) begin
                r_s_res <= 1'b0;
            end
        end
    end

    // window taps slide by one cell per request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur     <= item;
            r_t1      <= r_cur;
            r_t2      <= r_t1;
            r_m1a     <= m1;
            r_m1b     <= r_m1a;
            r_m2a     <= m2;
            r_m2b     <= r_m2a;
            r_s_col   <= r_rc;
            r_s_row   <= r_rr;
            r_s_last  <= res_last;
            r_s_flags <= n_flags;
        end
    end

    // one-column delay
    glmd_line_ram u_ram_col1 (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_wp),
        .i_wr_data (item),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_wp),
        .o_rd_data (m1)
    );

    // two-column delay, fed from the first store one request late
    glmd_line_ram u_ram_col2 (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_wp_prev),
        .i_wr_data (m1),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_wp),
        .o_rd_data (m2)
    );

    always_comb begin
        win.self  = r_m1a;
        win.c0_rm = r_m1b;
        win.c0_rp = m1;
        win.cp_rm = r_t2;
        win.cp_r0 = r_t1;
        win.cp_rp = r_cur;
        win.cm_rm = r_m2b;
        win.cm_rp = m2;
        // single-row map: the previous column sits just behind the one-column taps
        win.cm_r0 = (h_eff == HEIGHT_BITS'(1)) ? r_m1b : r_m2a;
    end

    glmd_window_eval u_eval (
        .i_win    (win),
        .i_flags  (r_s_flags),
        .o_is_min (is_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s_adv) begin
            r_ov <= r_s_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv && r_s_res) begin
            r_o_min  <= is_min;
            r_o_col  <= r_s_col;
            r_o_row  <= r_s_row;
            r_o_last <= r_s_last;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_is_local_min = r_o_min;
    assign o_cell_column  = r_o_col;
    assign o_cell_row     = r_o_row;
    assign o_last_cell    = r_o_last;

endmodule

`default_nettype wire
